// ----- src/rational_number_alu_defines.svh -----
// Assertion macros for the rational number ALU.
// Included by files that carry concurrent assertions; no dependencies.
`ifndef RATIONAL_NUMBER_ALU_DEFINES_SVH
`define RATIONAL_NUMBER_ALU_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define RNA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication outside reset.
`define RNA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- src/rna_pkg.sv -----
// Package for the rational number ALU: action codes, error codes, widths,
// request and response types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rna_pkg;
  localparam int unsigned FieldW = 32;
  localparam int unsigned DenOutW = 31;

  localparam logic [2:0] ACT_NORM = 3'd0;
  localparam logic [2:0] ACT_ADD  = 3'd1;
  localparam logic [2:0] ACT_SUB  = 3'd2;
  localparam logic [2:0] ACT_MUL  = 3'd3;
  localparam logic [2:0] ACT_DIV  = 3'd4;
  localparam logic [2:0] ACT_CMP  = 3'd5;

  localparam logic [1:0] ERR_OK   = 2'd0;
  localparam logic [1:0] ERR_ZERO = 2'd1;
  localparam logic [1:0] ERR_OVF  = 2'd2;

  typedef struct packed {
    logic [2:0]         action;
    logic [FieldW-1:0]  num_a;
    logic [FieldW-1:0]  den_a;
    logic [FieldW-1:0]  num_b;
    logic [FieldW-1:0]  den_b;
  } req_t;

  typedef struct packed {
    logic [FieldW-1:0]  res_num;
    logic [DenOutW-1:0] res_den;
    logic [1:0]         order;
    logic [1:0]         error;
  } rsp_t;
endpackage
`default_nettype wire

// ----- src/rna_if.sv -----
// Valid/ready channel interface carrying a packed payload.
// Depends on nothing; payload type given as parameter.
`timescale 1ns / 1ps
`default_nettype none
interface rna_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- src/rational_number_alu.sv -----
// Rational number ALU top level with its sequencer and shared datapath.
// Depends on rna_pkg, rna_if and rational_number_alu_defines.svh.
//
//  channel | dir | payload
//  in_if   | in  | action, num_a, den_a, num_b, den_b
//  out_if  | out | res_num, res_den, order, error
//
// One transaction at a time; its run time is set by the shared 64-bit
// restoring divider (one quotient bit a cycle) that serves the Euclid gcd
// steps and the divisions by the gcd; the gcd steps of the reductions (a;
// b unless normalizing; the result for add, sub, mul, div) dominate.
// rst_ni clears the sequencer and output valid. A stalled result holds in
// the output register; the next transaction is taken once it leaves.
`timescale 1ns / 1ps
`default_nettype none
`include "rational_number_alu_defines.svh"
module rational_number_alu #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input wire clk_i,
  input wire rst_ni,
  rna_if.sink   in_if,
  rna_if.source out_if
);
  import rna_pkg::*;

  localparam int unsigned W = 64;
  localparam int unsigned MW = 33;

  // sequencer codes
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_MKA   = 5'd1;  // reduce a
  localparam logic [4:0] S_MKB   = 5'd2;  // after reductions: finish norm, invert b for div
  localparam logic [4:0] S_M1    = 5'd3;  // product 1
  localparam logic [4:0] S_M2    = 5'd4;
  localparam logic [4:0] S_M3    = 5'd5;
  localparam logic [4:0] S_COMB  = 5'd6;
  localparam logic [4:0] S_RED   = 5'd7;  // start reduce of (rn, rd)
  localparam logic [4:0] S_GCD   = 5'd8;  // gcd: divide x by y
  localparam logic [4:0] S_DIVN  = 5'd9;  // n / g
  localparam logic [4:0] S_DIVD  = 5'd10; // d / g
  localparam logic [4:0] S_RDONE = 5'd11;
  localparam logic [4:0] S_FIN   = 5'd12;
  localparam logic [4:0] S_OUT   = 5'd13;

  // purpose of the current reduction
  localparam logic [1:0] P_A = 2'd0;
  localparam logic [1:0] P_B = 2'd1;
  localparam logic [1:0] P_R = 2'd2;

  logic [4:0]   state_q, state_d;
  logic [1:0]   purp_q;
  logic [2:0]   act_q;
  logic [1:0]   err_q;
  logic [1:0]   ord_q;
  logic signed [W-1:0] an_q, ad_q, bn_q, bd_q, rn_q, rd_q, p1_q, p2_q;
  logic [W-1:0] x_q, y_q, g_q;
  logic         neg_q;
  // shared divider
  logic [W-1:0] dvd_q, dvs_q, quo_q, rem_q;
  logic [6:0]   cnt_q;
  logic         busy_q;
  rsp_t         rsp_q;
  logic         ovld_q;

  function automatic logic signed [W-1:0] sx(input logic [FieldW-1:0] v);
    logic signed [W-1:0] r;
    r = W'(signed'(v[DATA_WIDTH-1:0]));
    return r;
  endfunction

  function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
    return v[W-1] ? W'(-v) : W'(v);
  endfunction

  // one multiplier, operands muxed by state; operands fit in 33 bits
  logic signed [MW-1:0]   ma, mb;
  logic signed [2*MW-1:0] mp;
  always_comb begin
    ma = '0;
    mb = '0;
    case (state_q)
      S_M1: begin
        ma = an_q[MW-1:0];
        mb = (act_q == ACT_MUL || act_q == ACT_DIV) ? bn_q[MW-1:0] : bd_q[MW-1:0];
      end
      S_M2:    begin ma = bn_q[MW-1:0]; mb = ad_q[MW-1:0]; end
      S_M3:    begin ma = ad_q[MW-1:0]; mb = bd_q[MW-1:0]; end
      default: begin ma = '0; mb = '0; end
    endcase
    mp = ma * mb;
  end

  // divider step
  logic [W:0]   trial;
  logic [W-1:0] rsh;
  always_comb begin
    rsh = {rem_q[W-2:0], dvd_q[W-1]};
    trial = {1'b0, rsh} - {1'b0, dvs_q};
  end

  logic signed [W-1:0] hi_lim, lo_lim;
  assign hi_lim = (W'(1) <<< (DATA_WIDTH-1)) - W'(1);
  assign lo_lim = -hi_lim - W'(1);

  assign in_if.ready = (state_q == S_IDLE) && !ovld_q;
  assign out_if.valid = ovld_q;
  assign out_if.data = rsp_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_if.valid && in_if.ready) state_d = S_MKA;
      default: state_d = state_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ovld_q  <= 1'b0;
      busy_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      if (out_if.valid && out_if.ready) ovld_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_if.valid && in_if.ready) begin
            act_q <= (in_if.data.action > ACT_CMP) ? ACT_NORM : in_if.data.action;
            an_q <= sx(in_if.data.num_a);
            ad_q <= sx(in_if.data.den_a);
            bn_q <= sx(in_if.data.num_b);
            bd_q <= sx(in_if.data.den_b);
            ord_q <= 2'b00;
            err_q <= ERR_OK;
            state_q <= state_d;
          end
        end
        S_MKA: begin
          // check zero denominators, then make a
          if (ad_q == 0 || (act_q != ACT_NORM && bd_q == 0)) begin
            err_q <= ERR_ZERO;
            state_q <= S_FIN;
          end else begin
            rn_q <= ad_q[W-1] ? -an_q : an_q;
            rd_q <= ad_q[W-1] ? -ad_q : ad_q;
            purp_q <= P_A;
            state_q <= S_RED;
          end
        end
        S_MKB: begin
          if (act_q == ACT_NORM) begin
            rn_q <= an_q; rd_q <= ad_q;
            state_q <= S_FIN;
          end else if (act_q == ACT_DIV) begin
            // b becomes its reciprocal; b reduced already so no gcd needed
            if (bn_q == 0) begin
              err_q <= ERR_ZERO;
              state_q <= S_FIN;
            end else begin
              bn_q <= bn_q[W-1] ? -bd_q : bd_q;
              bd_q <= bn_q[W-1] ? -bn_q : bn_q;
              state_q <= S_M1;
            end
          end else state_q <= S_M1;
        end
        S_M1: begin p1_q <= mp[W-1:0]; state_q <= S_M2; end
        S_M2: begin p2_q <= mp[W-1:0]; state_q <= S_M3; end
        S_M3: begin rd_q <= mp[W-1:0]; state_q <= S_COMB; end
        S_COMB: begin
          case (act_q)
            ACT_ADD: rn_q <= p1_q + p2_q;
            ACT_SUB: rn_q <= p1_q - p2_q;
            default: rn_q <= p1_q;
          endcase
          if (act_q == ACT_CMP) begin
            ord_q <= (p1_q < p2_q) ? 2'b11 : ((p1_q > p2_q) ? 2'b01 : 2'b00);
            state_q <= S_FIN;
          end else begin
            purp_q <= P_R;
            state_q <= S_RED;
          end
        end
        S_RED: begin
          neg_q <= rn_q[W-1];
          x_q <= mag(rn_q);
          y_q <= rd_q;
          state_q <= S_GCD;
        end
        S_GCD: begin
          if (!busy_q) begin
            if (y_q == 0) begin
              g_q <= (x_q == 0) ? W'(1) : x_q;
              dvd_q <= mag(rn_q); dvs_q <= (x_q == 0) ? W'(1) : x_q;
              rem_q <= '0; cnt_q <= '0; busy_q <= 1'b1;
              state_q <= S_DIVN;
            end else begin
              dvd_q <= x_q; dvs_q <= y_q; rem_q <= '0; cnt_q <= '0;
              busy_q <= 1'b1;
            end
          end else if (cnt_q == 7'(W)) begin
            busy_q <= 1'b0;
            x_q <= y_q;
            y_q <= rem_q;
          end
        end
        S_DIVN: begin
          if (busy_q && cnt_q == 7'(W)) begin
            rn_q <= neg_q ? -signed'(quo_q) : signed'(quo_q);
            dvd_q <= rd_q; dvs_q <= g_q; rem_q <= '0; cnt_q <= '0;
            state_q <= S_DIVD;
          end
        end
        S_DIVD: begin
          if (busy_q && cnt_q == 7'(W)) begin
            rd_q <= signed'(quo_q);
            busy_q <= 1'b0;
            state_q <= S_RDONE;
          end
        end
        S_RDONE: begin
          case (purp_q)
            P_A: begin an_q <= rn_q; ad_q <= rd_q; state_q <= S_MKB; end
            P_B: begin bn_q <= rn_q; bd_q <= rd_q; state_q <= S_MKB; end
            default: state_q <= S_FIN;
          endcase
          if (purp_q == P_A && act_q != ACT_NORM) begin
            rn_q <= bd_q[W-1] ? -bn_q : bn_q;
            rd_q <= bd_q[W-1] ? -bd_q : bd_q;
            purp_q <= P_B;
            state_q <= S_RED;
          end
        end
        S_FIN: begin
          rsp_q.order <= ord_q;
          if (err_q != ERR_OK || act_q == ACT_CMP) begin
            rsp_q.error <= err_q;
            rsp_q.res_num <= '0;
            rsp_q.res_den <= '0;
          end else if (rn_q > hi_lim || rn_q < lo_lim || rd_q > hi_lim) begin
            rsp_q.error <= ERR_OVF;
            rsp_q.res_num <= '0;
            rsp_q.res_den <= '0;
          end else begin
            rsp_q.error <= ERR_OK;
            rsp_q.res_num <= rn_q[FieldW-1:0];
            rsp_q.res_den <= rd_q[DenOutW-1:0];
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          ovld_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
      // advance the shared divider one bit
      if (busy_q && cnt_q != 7'(W)) begin
        rem_q <= trial[W] ? rsh : trial[W-1:0];
        quo_q <= {quo_q[W-2:0], ~trial[W]};
        dvd_q <= {dvd_q[W-2:0], 1'b0};
        cnt_q <= cnt_q + 7'd1;
      end
    end
  end

  `RNA_ASSERT_IMP(a_no_accept_busy, clk_i, rst_ni, state_q != S_IDLE, !in_if.ready)
  `RNA_ASSERT_NXT(a_hold_out, clk_i, rst_ni, out_if.valid && !out_if.ready, out_if.valid)
  `RNA_ASSERT_IMP(a_den_pos, clk_i, rst_ni, out_if.valid && out_if.data.error == ERR_OK && out_if.data.order == 2'b00 && out_if.data.res_den != '0, out_if.data.res_den != '0)
endmodule
`default_nettype wire
